@@ rtl/wshp_pkg.sv @@
// wshp_pkg: types, codes and helper functions for the websocket header parser
// no dependencies; used by every other file of the block but the two interfaces

package wshp_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_PROTOCOL   = 2'd2
    } status_t;

    localparam logic [7:0] FIN_MASK     = 8'h80;
    localparam logic [7:0] OPCODE_MASK  = 8'h0F;
    localparam logic [7:0] LEN_MASK     = 8'h7F;
    localparam logic [6:0] LEN_MAX_7BIT = 7'd125;
    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [3:0] RSV_LO_A     = 4'h3;
    localparam logic [3:0] RSV_HI_A     = 4'h7;
    localparam logic [3:0] RSV_LO_B     = 4'hB;
    localparam logic [3:0] RSV_HI_B     = 4'hF;
    localparam logic [3:0] CONTROL_MIN  = 4'h8;
    localparam logic [3:0] BASE_HDR     = 4'd2;
    localparam logic [3:0] EXT_16_BYTES = 4'd2;
    localparam logic [3:0] EXT_64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;
    localparam logic [63:0] CTRL_LEN_MAX = 64'd125;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } beat_t;

    typedef struct packed {
        status_t     status;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        masked_flag;
        logic [63:0] payload_length;
        logic [31:0] key_word;
        logic [3:0]  hdr_len;
    } result_t;

    typedef struct packed {
        logic take;
        logic emit;
    } dec_ctl_t;

    function automatic logic opcode_reserved(input logic [3:0] op);
        opcode_reserved = (op inside {[RSV_LO_A:RSV_HI_A], [RSV_LO_B:RSV_HI_B]});
    endfunction

    function automatic logic [3:0] ext_bytes(input logic [7:0] code_byte);
        logic [6:0] code;
        code = code_byte[6:0];
        case (code)
            LEN_CODE_16: ext_bytes = EXT_16_BYTES;
            LEN_CODE_64: ext_bytes = EXT_64_BYTES;
            default:     ext_bytes = 4'd0;
        endcase
    endfunction

    function automatic logic [3:0] header_total(input logic [7:0] code_byte);
        header_total = BASE_HDR + ext_bytes(code_byte)
                     + (code_byte[7] ? KEY_BYTES : 4'd0);
    endfunction

endpackage

@@ rtl/wshp_byte_if.sv @@
// wshp_byte_if: valid/ready channel carrying one buffer byte per beat
// no dependencies

interface wshp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

@@ rtl/wshp_hdr_if.sv @@
// wshp_hdr_if: valid/ready channel carrying one decoded header result per beat
// no dependencies

interface wshp_hdr_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        masked_flag;
    logic [63:0] payload_length;
    logic [31:0] key_word;
    logic [3:0]  hdr_len;

    modport source (output valid, output status, output fin_flag, output frame_opcode,
                    output masked_flag, output payload_length, output key_word,
                    output hdr_len, input ready);
    modport sink   (input valid, input status, input fin_flag, input frame_opcode,
                    input masked_flag, input payload_length, input key_word,
                    input hdr_len, output ready);
endinterface

@@ rtl/wshp_in_stage.sv @@
// wshp_in_stage: input register holding one byte beat for the decoder
// depends on wshp_pkg and wshp_byte_if

module wshp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    wshp_byte_if.sink          bytes,
    input  wshp_pkg::dec_ctl_t ctl,
    output logic               beat_valid,
    output wshp_pkg::beat_t    beat
);

    logic            valid_reg;
    logic            valid_next;
    wshp_pkg::beat_t beat_reg;
    logic            accept;

    assign bytes.ready = !valid_reg || ctl.take;
    assign accept      = bytes.valid && bytes.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (ctl.take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg.data_byte     <= bytes.data_byte;
            beat_reg.end_of_buffer <= bytes.end_of_buffer;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

@@ rtl/wshp_decode.sv @@
// wshp_decode: header parse state and single-pass decode of the registered byte
// depends on wshp_pkg

module wshp_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               beat_valid,
    input  wshp_pkg::beat_t    beat,
    input  logic               out_free,
    output wshp_pkg::dec_ctl_t ctl,
    output wshp_pkg::result_t  res
);

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic        drain_reg;
    logic        drain_next;
    logic [7:0]  first_reg;
    logic [7:0]  first_next;
    logic [7:0]  code_reg;
    logic [7:0]  code_next;
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [31:0] key_reg;
    logic [31:0] key_next;

    logic           emit;
    logic           fin_end;
    wshp_pkg::status_t st;
    logic [3:0]     total;
    logic [4:0]     pos_inc;
    logic           is_ctrl;
    logic [7:0]     b;
    logic           e;

    assign b = beat.data_byte;
    assign e = beat.end_of_buffer;

    always_comb
    begin
        pos_next   = pos_reg;
        drain_next = drain_reg;
        first_next = first_reg;
        code_next  = code_reg;
        len_next   = len_reg;
        key_next   = key_reg;
        emit       = 1'b0;
        fin_end    = 1'b0;
        st         = wshp_pkg::ST_OK;
        total      = 4'd0;
        pos_inc    = {1'b0, pos_reg} + 5'd1;
        is_ctrl    = 1'b0;

        if (drain_reg)
        begin
            if (e)
            begin
                drain_next = 1'b0;
                pos_next   = 4'd0;
            end
        end
        else if (pos_reg == 4'd0)
        begin
            first_next = b;
            code_next  = 8'd0;
            len_next   = 64'd0;
            key_next   = 32'd0;
            pos_next   = 4'd1;
            if (e)
            begin
                emit    = 1'b1;
                fin_end = 1'b1;
                st      = wshp_pkg::ST_INCOMPLETE;
            end
        end
        else if (pos_reg == 4'd1 && wshp_pkg::opcode_reserved(first_reg[3:0]))
        begin
            code_next = b;
            emit      = 1'b1;
            fin_end   = 1'b1;
            st        = wshp_pkg::ST_PROTOCOL;
        end
        else
        begin
            if (pos_reg == 4'd1)
            begin
                code_next = b;
                len_next  = ((b & wshp_pkg::LEN_MASK) <= {1'b0, wshp_pkg::LEN_MAX_7BIT})
                          ? {56'd0, b & wshp_pkg::LEN_MASK} : 64'd0;
            end
            else if ({1'b0, pos_reg} < {1'b0, wshp_pkg::BASE_HDR}
                                       + {1'b0, wshp_pkg::ext_bytes(code_reg)})
            begin
                len_next = {len_reg[55:0], b};
            end
            else
            begin
                key_next = {key_reg[23:0], b};
            end

            total   = wshp_pkg::header_total(code_next);
            is_ctrl = ((first_reg & wshp_pkg::OPCODE_MASK) >= {4'd0, wshp_pkg::CONTROL_MIN});
            if (pos_inc >= {1'b0, total})
            begin
                emit    = 1'b1;
                fin_end = 1'b1;
                if (is_ctrl && (len_next > wshp_pkg::CTRL_LEN_MAX
                                || (first_reg & wshp_pkg::FIN_MASK) == 8'd0))
                begin
                    st = wshp_pkg::ST_PROTOCOL;
                end
                else
                begin
                    st = wshp_pkg::ST_OK;
                end
            end
            else
            begin
                pos_next = pos_inc[3:0];
                if (e)
                begin
                    emit    = 1'b1;
                    fin_end = 1'b1;
                    st      = wshp_pkg::ST_INCOMPLETE;
                end
            end
        end

        // result closes the buffer or starts the skip to the end flag
        if (fin_end)
        begin
            if (e)
            begin
                pos_next   = 4'd0;
                drain_next = 1'b0;
            end
            else
            begin
                drain_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        res.status         = st;
        res.fin_flag       = first_next[7];
        res.frame_opcode   = first_next[3:0];
        res.masked_flag    = code_next[7];
        res.payload_length = 64'd0;
        res.key_word       = 32'd0;
        res.hdr_len        = 4'd0;
        if (st == wshp_pkg::ST_OK)
        begin
            res.payload_length = len_next;
            res.key_word       = code_next[7] ? key_next : 32'd0;
            res.hdr_len        = wshp_pkg::header_total(code_next);
        end
    end

    assign ctl.emit = beat_valid && emit;
    assign ctl.take = beat_valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            drain_reg <= 1'b0;
        end
        else if (ctl.take)
        begin
            pos_reg   <= pos_next;
            drain_reg <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            first_reg <= first_next;
            code_reg  <= code_next;
            len_reg   <= len_next;
            key_reg   <= key_next;
        end
    end

endmodule

@@ rtl/wshp_out_stage.sv @@
// wshp_out_stage: result register driving the header result channel
// depends on wshp_pkg and wshp_hdr_if

module wshp_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  wshp_pkg::dec_ctl_t ctl,
    input  wshp_pkg::result_t  res,
    output logic               out_free,
    wshp_hdr_if.source         result
);

    logic              valid_reg;
    logic              valid_next;
    wshp_pkg::result_t res_reg;
    logic              load;

    assign out_free = !valid_reg || result.ready;
    assign load     = ctl.take && ctl.emit;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid          = valid_reg;
    assign result.status         = res_reg.status;
    assign result.fin_flag       = res_reg.fin_flag;
    assign result.frame_opcode   = res_reg.frame_opcode;
    assign result.masked_flag    = res_reg.masked_flag;
    assign result.payload_length = res_reg.payload_length;
    assign result.key_word       = res_reg.key_word;
    assign result.hdr_len        = res_reg.hdr_len;

endmodule

@@ rtl/websocket_header_parser.sv @@
// websocket_header_parser: top level of the websocket frame header decoder
// depends on wshp_pkg, wshp_byte_if, wshp_hdr_if, wshp_in_stage, wshp_decode,
// wshp_out_stage
//
//   channel   direction  beat
//   bytes     in         one buffer byte with its end-of-buffer flag
//   result    out        one decoded header per buffer
//
// one byte per cycle unless a full result register stalls; a byte sits in the
// input register and its decode is registered into the result register when
// the decoder takes it, so a result is valid once its last byte is taken
// throughput is set by the single decode stage between the two registers
// reset clears the valid flags and parse position; no clearing pass
// a full result register stalls only a byte that would produce a new result

module websocket_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    wshp_byte_if.sink   bytes,
    wshp_hdr_if.source  result
);

    wshp_pkg::dec_ctl_t ctl;
    wshp_pkg::beat_t    beat;
    wshp_pkg::result_t  res;
    logic               beat_valid;
    logic               out_free;

    wshp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .ctl        (ctl),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    wshp_decode u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat       (beat),
        .out_free   (out_free),
        .ctl        (ctl),
        .res        (res)
    );

    wshp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .res      (res),
        .out_free (out_free),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.take && ctl.emit) |-> out_free)
        else $error("result loaded into a busy result register");

    a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == wshp_pkg::ST_OK)
            |-> (result.hdr_len >= 4'd2 && result.hdr_len <= 4'd14))
        else $error("ok header with impossible size");

    a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != wshp_pkg::ST_OK)
            |-> (result.payload_length == 64'd0 && result.key_word == 32'd0
                 && result.hdr_len == 4'd0))
        else $error("failed header carries length, key or size");

    a_take_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take |-> beat_valid)
        else $error("decoder consumed an empty input register");
`endif

endmodule

@@ sim/wshp_hdr_checker.sv @@
`timescale 1ns / 100ps
// wshp_hdr_checker: watches the byte and result channels of the header parser,
// predicts each decoded header from the accepted bytes and compares every result beat
// depends on wshp_pkg, wshp_byte_if and wshp_hdr_if

module wshp_hdr_checker (
    input  logic clk,
    input  logic rst_n,
    wshp_byte_if bytes,
    wshp_hdr_if  result,
    output int   errors,
    output int   pending
);

    wshp_pkg::result_t expected_headers[$];
    logic [3:0]  hdr_pos;
    logic        skipping;
    logic [7:0]  hdr_byte0;
    logic [7:0]  hdr_byte1;
    logic [63:0] len_acc;
    logic [31:0] key_acc;

    function automatic logic is_reserved_op(input logic [3:0] op);
        is_reserved_op = (op >= wshp_pkg::RSV_LO_A && op <= wshp_pkg::RSV_HI_A)
                      || (op >= wshp_pkg::RSV_LO_B && op <= wshp_pkg::RSV_HI_B);
    endfunction

    function automatic logic [3:0] ext_len(input logic [7:0] code_byte);
        if (code_byte[6:0] == wshp_pkg::LEN_CODE_64)
            ext_len = 4'd8;
        else if (code_byte[6:0] == wshp_pkg::LEN_CODE_16)
            ext_len = 4'd2;
        else
            ext_len = 4'd0;
    endfunction

    function automatic logic [3:0] header_len(input logic [7:0] code_byte);
        header_len = 4'd2 + ext_len(code_byte) + (code_byte[7] ? 4'd4 : 4'd0);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
        errors = errors + 1;
    endtask

    task automatic compare_field(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    task automatic close_header(input wshp_pkg::status_t st, input logic eob);
        wshp_pkg::result_t hdr;
        hdr = '0;
        hdr.status       = st;
        hdr.fin_flag     = hdr_byte0[7];
        hdr.frame_opcode = hdr_byte0[3:0];
        hdr.masked_flag  = hdr_byte1[7];
        if (st == wshp_pkg::ST_OK)
        begin
            hdr.payload_length = len_acc;
            hdr.key_word       = hdr_byte1[7] ? key_acc : 32'd0;
            hdr.hdr_len        = header_len(hdr_byte1);
        end
        expected_headers.push_back(hdr);
        if (eob)
        begin
            hdr_pos  = 4'd0;
            skipping = 1'b0;
        end
        else
            skipping = 1'b1;
    endtask

    task automatic decode_header_byte(input logic [7:0] b, input logic eob);
        logic [3:0] total;
        if (skipping)
        begin
            if (eob)
            begin
                skipping = 1'b0;
                hdr_pos  = 4'd0;
            end
        end
        else if (hdr_pos == 4'd0)
        begin
            hdr_byte0 = b;
            hdr_byte1 = 8'd0;
            len_acc   = 64'd0;
            key_acc   = 32'd0;
            hdr_pos   = 4'd1;
            if (eob)
                close_header(wshp_pkg::ST_INCOMPLETE, 1'b1);
        end
        else if (hdr_pos == 4'd1 && is_reserved_op(hdr_byte0[3:0]))
        begin
            hdr_byte1 = b;
            close_header(wshp_pkg::ST_PROTOCOL, eob);
        end
        else
        begin
            if (hdr_pos == 4'd1)
            begin
                hdr_byte1 = b;
                len_acc   = (b[6:0] <= wshp_pkg::LEN_MAX_7BIT) ? {57'd0, b[6:0]} : 64'd0;
            end
            else if (hdr_pos < 4'd2 + ext_len(hdr_byte1))
                len_acc = {len_acc[55:0], b};
            else
                key_acc = {key_acc[23:0], b};
            total = header_len(hdr_byte1);
            if (hdr_pos + 4'd1 >= total)
            begin
                // control frames must be final and short
                if (hdr_byte0[3:0] >= wshp_pkg::CONTROL_MIN
                    && (len_acc > wshp_pkg::CTRL_LEN_MAX || !hdr_byte0[7]))
                    close_header(wshp_pkg::ST_PROTOCOL, eob);
                else
                    close_header(wshp_pkg::ST_OK, eob);
            end
            else
            begin
                hdr_pos = hdr_pos + 4'd1;
                if (eob)
                    close_header(wshp_pkg::ST_INCOMPLETE, 1'b1);
            end
        end
    endtask

    task automatic check_header();
        wshp_pkg::result_t want;
        if (expected_headers.size() == 0)
            report_mismatch("result beat with no header expected",
                            64'(result.status), 64'd0);
        else
        begin
            want = expected_headers.pop_front();
            compare_field("status", 64'(result.status), 64'(want.status));
            compare_field("fin_flag", 64'(result.fin_flag), 64'(want.fin_flag));
            compare_field("frame_opcode", 64'(result.frame_opcode), 64'(want.frame_opcode));
            compare_field("masked_flag", 64'(result.masked_flag), 64'(want.masked_flag));
            compare_field("payload_length", result.payload_length, want.payload_length);
            compare_field("key_word", 64'(result.key_word), 64'(want.key_word));
            compare_field("hdr_len", 64'(result.hdr_len), 64'(want.hdr_len));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos   = 4'd0;
            skipping  = 1'b0;
            hdr_byte0 = 8'd0;
            hdr_byte1 = 8'd0;
            len_acc   = 64'd0;
            key_acc   = 32'd0;
            errors    = 0;
            expected_headers.delete();
        end
        else
        begin
            if (bytes.valid === 1'b1 && bytes.ready === 1'b1)
                decode_header_byte(bytes.data_byte, bytes.end_of_buffer);
            if (result.valid === 1'b1 && result.ready === 1'b1)
                check_header();
        end
        pending = expected_headers.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: drives byte buffers into websocket_header_parser with random idling
// and back-pressure; wshp_hdr_checker predicts and compares the results
// depends on wshp_pkg, wshp_byte_if, wshp_hdr_if, wshp_hdr_checker and the block

module tb_top;

    localparam int HEADER_BYTES_TARGET = 1400;
    localparam int CYCLE_LIMIT         = 400000;

    logic  clk;
    logic  rst_n;
    int    cycle_count = 0;
    int    errors;
    int    pending;
    int    header_beats = 0;
    wshp_pkg::beat_t stream_beats[$];

    wshp_byte_if bytes_ch();
    wshp_hdr_if  result_ch();

    websocket_header_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes_ch),
        .result (result_ch)
    );

    wshp_hdr_checker hdr_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_ch),
        .result  (result_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // cut: bytes delivered before an early end (0 = whole header)
    // trail: payload bytes after the header, the last one carrying the end flag
    task automatic add_frame(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [63:0] ext_val, input logic [31:0] key,
                             input int cut, input int trail);
        logic [7:0] hdr[$];
        wshp_pkg::beat_t beat;
        int         n_ext;
        int         n_send;
        int         i;
        hdr.push_back(b0);
        hdr.push_back(b1);
        n_ext = (b1[6:0] == wshp_pkg::LEN_CODE_16) ? 2
              : (b1[6:0] == wshp_pkg::LEN_CODE_64) ? 8 : 0;
        for (i = n_ext - 1; i >= 0; i--)
            hdr.push_back(ext_val[8*i +: 8]);
        if (b1[7])
            for (i = 3; i >= 0; i--)
                hdr.push_back(key[8*i +: 8]);
        n_send = (cut > 0 && cut < hdr.size()) ? cut : hdr.size();
        if (n_send < hdr.size())
            trail = 0;
        for (i = 0; i < n_send; i++)
        begin
            beat.data_byte     = hdr[i];
            beat.end_of_buffer = (i == n_send - 1) && (trail == 0);
            stream_beats.push_back(beat);
        end
        for (i = 0; i < trail; i++)
        begin
            beat.data_byte     = 8'($urandom);
            beat.end_of_buffer = (i == trail - 1);
            stream_beats.push_back(beat);
        end
        header_beats += n_send + trail;
    endtask

    task automatic add_noise(input int len);
        wshp_pkg::beat_t beat;
        int    i;
        for (i = 0; i < len; i++)
        begin
            beat.data_byte     = 8'($urandom);
            beat.end_of_buffer = (i == len - 1);
            stream_beats.push_back(beat);
        end
        header_beats += len;
    endtask

    task automatic add_random_frame();
        logic [3:0]  op;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [63:0] ext_val;
        logic        control;
        int          pick;
        int          cut;
        int          trail;
        if ($urandom_range(0, 99) < 8)
            op = $urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
        else
        begin
            case ($urandom_range(0, 5))
                0:       op = 4'h0;
                1:       op = 4'h1;
                2:       op = 4'h2;
                3:       op = 4'h8;
                4:       op = 4'h9;
                default: op = 4'hA;
            endcase
        end
        control = (op >= wshp_pkg::CONTROL_MIN);
        b0 = {($urandom_range(0, 9) != 0), 3'($urandom), op};
        b1[7] = 1'($urandom);
        ext_val = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            case ($urandom_range(0, 7))
                0:       b1[6:0] = 7'd0;
                1:       b1[6:0] = wshp_pkg::LEN_MAX_7BIT;
                default: b1[6:0] = 7'($urandom_range(0, 125));
            endcase
        end
        else if (pick < 78)
            b1[6:0] = wshp_pkg::LEN_CODE_16;
        else
            b1[6:0] = wshp_pkg::LEN_CODE_64;
        case ($urandom_range(0, 7))
            0:       ext_val = '1;
            1:       ext_val = '0;
            2, 3:    if (control) ext_val = 64'($urandom_range(0, 130));
            default: ;
        endcase
        cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        trail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
        add_frame(b0, b1, ext_val, $urandom, cut, trail);
    endtask

    task automatic build_stimulus();
        // well-formed edges, control frame rules, reserved opcodes and early buffer ends
        add_frame(8'h81, 8'h00, 64'd0, 32'd0, 0, 0);
        add_frame(8'h82, 8'hFD, 64'd0, 32'hFFFF_FFFF, 0, 1);
        add_frame(8'h02, 8'h7E, 64'hFFFF, 32'd0, 0, 0);
        add_frame(8'h80, 8'hFF, '1, 32'h0102_0304, 0, 0);
        add_frame(8'hF3, 8'h85, 64'd0, 32'd0, 0, 2);
        add_frame(8'h7F, 8'h00, 64'd0, 32'd0, 0, 0);
        add_frame(8'h89, 8'h7E, 64'd126, 32'd0, 0, 0);
        add_frame(8'h08, 8'h00, 64'd0, 32'd0, 0, 0);
        add_frame(8'h8A, 8'hFD, 64'd0, 32'h5A5A_A5A5, 0, 0);
        add_frame(8'h88, 8'h7E, 64'd100, 32'd0, 0, 0);
        add_frame(8'h01, 8'h00, 64'd0, 32'd0, 1, 0);
        add_frame(8'h82, 8'hFF, 64'h0123_4567_89AB_CDEF, 32'd0, 5, 0);
        while (header_beats < HEADER_BYTES_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                add_noise($urandom_range(1, 16));
            else
                add_random_frame();
        end
    endtask

    task automatic send_beats();
        wshp_pkg::beat_t beat;
        int    gap;
        logic  calm;
        calm = 1'b0;
        while (stream_beats.size() > 0)
        begin
            beat = stream_beats.pop_front();
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 17);
            repeat (gap)
            begin
                bytes_ch.valid <= 1'b0;
                @(posedge clk);
            end
            bytes_ch.valid         <= 1'b1;
            bytes_ch.data_byte     <= beat.data_byte;
            bytes_ch.end_of_buffer <= beat.end_of_buffer;
            do
                @(posedge clk);
            while (bytes_ch.ready !== 1'b1);
        end
        bytes_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic calm;
        int   stall;
        calm = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 17);
            repeat (stall)
            begin
                result_ch.ready <= 1'b0;
                @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_ch.valid !== 1'b1);
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        bytes_ch.valid         = 1'b0;
        bytes_ch.data_byte     = 8'd0;
        bytes_ch.end_of_buffer = 1'b0;
        build_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        send_beats();
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/wshp_pkg.sv
rtl/wshp_byte_if.sv
rtl/wshp_hdr_if.sv
rtl/wshp_in_stage.sv
rtl/wshp_decode.sv
rtl/wshp_out_stage.sv
rtl/websocket_header_parser.sv
sim/wshp_hdr_checker.sv
sim/tb_top.sv
